FILE: src/pdrm_pkg.sv
// ----------------------------------------------------------------------------
// pdrm_pkg
// shared types and constants of the packet descriptor ring manager
// ----------------------------------------------------------------------------
package pdrm_pkg;

  localparam int unsigned DataBytesDefault   = 1048576;
  localparam int unsigned DescriptorsDefault = 256;

  localparam int OfsW   = 20;
  localparam int LenW   = 21;
  localparam int FlagW  = 8;
  localparam int StampW = 63;
  localparam int CntW   = 9;

  typedef enum logic [2:0] {
    OP_RESERVE    = 3'd0,
    OP_COMMIT     = 3'd1,
    OP_GET        = 3'd2,
    OP_GET_RUN    = 3'd3,
    OP_RELEASE    = 3'd4,
    OP_INVALIDATE = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RES_RD,
    ST_RES_EV,
    ST_CMT_RD,
    ST_GET_RD,
    ST_RUN_RD,
    ST_RUN_EV
  } state_t;

endpackage

FILE: src/packet_descriptor_ring_manager.sv
// ----------------------------------------------------------------------------
// packet_descriptor_ring_manager
// descriptor ring bookkeeping for a store of variable-size packets
// ----------------------------------------------------------------------------
// One transaction at a time: start is taken while busy is low, and exactly one
// result appears later on the result ports for a single cycle with done high.
// The receiver cannot stall; done is a strobe and must be captured when seen.
// Invalidate, release, undefined ops, a stale commit, a reserve on an empty or
// full ring, and a get or get run that flushes or finds the ring empty answer
// straight from the idle state; other commits and gets answer after one
// descriptor memory read; other reserves after the newest and oldest descriptor
// reads; a get run that walks makes one memory read per descriptor walked.
// Descriptors live in one synchronous memory with a registered read; the
// block's pointers and hold state live in flip-flops.
// No clearing pass is needed after reset.
module packet_descriptor_ring_manager
  import pdrm_pkg::*;
#(
  parameter int unsigned DATA_BYTES  = DataBytesDefault,
  parameter int unsigned DESCRIPTORS = DescriptorsDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        op,
  input  logic [LenW-1:0]   length,
  input  logic [FlagW-1:0]  packet_flags,
  input  logic [StampW-1:0] stamp,
  input  logic [LenW-1:0]   max_total,
  output logic              done,
  output logic              ok,
  output logic [OfsW-1:0]   offset,
  output logic [LenW-1:0]   out_length,
  output logic [FlagW-1:0]  out_flags,
  output logic [StampW-1:0] out_stamp,
  output logic [CntW-1:0]   count
);

  localparam int IdxW  = (DESCRIPTORS > 2) ? $clog2(DESCRIPTORS) : 1;
  localparam int HcW   = IdxW + 1;
  localparam int SumW  = LenW + 2;
  localparam int EntW  = OfsW + LenW + LenW + FlagW + StampW;
  localparam logic [SumW-1:0] DataLim = SumW'(DATA_BYTES);

  // descriptor memory: offset, reserved, length, flags, stamp
  logic [EntW-1:0] mem [DESCRIPTORS];
  logic [EntW-1:0] rd_data;
  logic [IdxW-1:0] rd_addr;
  logic            wr_en;
  logic [IdxW-1:0] wr_addr;
  logic [EntW-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  logic [OfsW-1:0]   rd_ofs;
  logic [LenW-1:0]   rd_res, rd_len;
  logic [FlagW-1:0]  rd_flg;
  logic [StampW-1:0] rd_stp;
  assign {rd_ofs, rd_res, rd_len, rd_flg, rd_stp} = rd_data;

  function automatic logic [IdxW-1:0] inc_idx(input logic [IdxW-1:0] i);
    logic [IdxW:0] s;
    s = {1'b0, i} + 1'b1;
    if (s == (IdxW+1)'(DESCRIPTORS)) s = '0;
    return s[IdxW-1:0];
  endfunction

  // control state
  state_t          state, state_next;
  logic [IdxW-1:0] write_index, read_index, held_index;
  logic            write_pending, read_held, flush_request;
  logic [HcW-1:0]  held_count;

  // captured transaction
  logic [LenW-1:0]   req_len, req_max;
  logic [FlagW-1:0]  req_flags;
  logic [StampW-1:0] req_stamp;

  // working registers
  logic [OfsW-1:0]  new_ofs;
  logic [SumW-1:0]  new_end;
  logic [IdxW-1:0]  walk_idx;
  logic [SumW-1:0]  run_total, run_end;
  logic [HcW-1:0]   run_cnt;
  logic [FlagW-1:0] run_flags;
  logic [StampW-1:0] run_stamp;
  logic [OfsW-1:0]  run_ofs;

  // result register
  logic              r_done, r_ok;
  logic [OfsW-1:0]   r_ofs;
  logic [LenW-1:0]   r_len;
  logic [FlagW-1:0]  r_flg;
  logic [StampW-1:0] r_stp;
  logic [CntW-1:0]   r_cnt;

  assign busy       = (state != ST_IDLE);
  assign done       = r_done;
  assign ok         = r_ok;
  assign offset     = r_ofs;
  assign out_length = r_len;
  assign out_flags  = r_flg;
  assign out_stamp  = r_stp;
  assign count      = r_cnt;

  logic accept;
  assign accept = start && !busy;

  // reserve space test, done once the newest end and oldest offset are known
  logic [SumW-1:0] need_end;
  logic            fit_end, fit_zero, wrapped;
  assign wrapped  = ({{(SumW-OfsW){1'b0}}, rd_ofs} > {{(SumW-OfsW){1'b0}}, new_ofs});
  assign need_end = new_end + SumW'(req_len);
  assign fit_end  = wrapped ? (need_end <= SumW'(rd_ofs)) : (need_end < DataLim);
  assign fit_zero = !wrapped && (req_len < LenW'(rd_ofs));

  // run walk test on the descriptor just read
  logic [SumW-1:0] join_total;
  logic            run_stop, run_join;
  assign join_total = run_total + SumW'(rd_len);
  assign run_stop   = (walk_idx == write_index) || (run_cnt == HcW'(DESCRIPTORS));
  assign run_join   = !run_stop && (SumW'(rd_ofs) == run_end) &&
                      (join_total <= SumW'(req_max)) && (rd_flg == '0);

  logic [LenW-1:0] clip_len;
  assign clip_len = (req_len > rd_res) ? rd_res : req_len;

  // release advance, wrapped by a single compare and subtract
  logic [HcW:0]    rel_sum;
  logic [IdxW-1:0] rel_index;
  assign rel_sum   = {1'b0, held_count} + {2'b0, read_index};
  assign rel_index = (rel_sum >= (HcW+1)'(DESCRIPTORS)) ?
                     IdxW'(rel_sum - (HcW+1)'(DESCRIPTORS)) : IdxW'(rel_sum);

  // empty ring reserve is answered at once and written at acceptance
  logic res_empty_ok;
  assign res_empty_ok = accept && (op == OP_RESERVE) &&
                        (inc_idx(write_index) != read_index) &&
                        (read_index == write_index) && ({2'b0, length} <= DataLim);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (op)
            OP_RESERVE:
              if (inc_idx(write_index) != read_index && read_index != write_index)
                state_next = ST_RES_RD;
            OP_COMMIT:  if (write_pending) state_next = ST_CMT_RD;
            OP_GET:
              if (read_held || (!flush_request && read_index != write_index))
                state_next = ST_GET_RD;
            OP_GET_RUN:
              if (!flush_request && read_index != write_index) state_next = ST_RUN_RD;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_RES_RD: state_next = ST_RES_EV;
      ST_RUN_RD: state_next = ST_RUN_EV;
      ST_RUN_EV: if (!run_join) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    rd_addr = walk_idx;
    wr_en   = 1'b0;
    wr_addr = write_index;
    wr_data = rd_data;
    case (state)
      ST_IDLE: begin
        case (op)
          OP_RESERVE: begin
            rd_addr = write_index - 1'b1;
            if (write_index == '0) rd_addr = IdxW'(DESCRIPTORS - 1);
            if (res_empty_ok) begin
              wr_en   = 1'b1;
              wr_data = {{OfsW{1'b0}}, length, {LenW{1'b0}}, {FlagW{1'b0}},
                         {StampW{1'b0}}};
            end
          end
          OP_COMMIT: rd_addr = write_index;
          OP_GET:    rd_addr = read_held ? held_index : read_index;
          default:   rd_addr = read_index;
        endcase
      end
      ST_RES_RD: rd_addr = read_index;
      ST_RES_EV: begin
        wr_en   = fit_end || fit_zero;
        wr_data = {fit_end ? new_end[OfsW-1:0] : {OfsW{1'b0}}, req_len,
                   {LenW{1'b0}}, {FlagW{1'b0}}, {StampW{1'b0}}};
      end
      ST_CMT_RD: begin
        wr_en   = 1'b1;
        wr_data = {rd_ofs, rd_res, clip_len, req_flags, req_stamp};
      end
      ST_RUN_RD: rd_addr = inc_idx(walk_idx);
      ST_RUN_EV: rd_addr = inc_idx(walk_idx);
      default: rd_addr = walk_idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      write_index   <= '0;
      read_index    <= '0;
      held_index    <= '0;
      held_count    <= '0;
      write_pending <= 1'b0;
      read_held     <= 1'b0;
      flush_request <= 1'b0;
      r_done        <= 1'b0;
    end else begin
      state  <= state_next;
      r_done <= 1'b0;
      r_ok   <= 1'b0;
      r_ofs  <= '0;
      r_len  <= '0;
      r_flg  <= '0;
      r_stp  <= '0;
      r_cnt  <= '0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            req_len   <= length;
            req_max   <= max_total;
            req_flags <= packet_flags;
            req_stamp <= stamp;
            case (op)
              OP_RESERVE: begin
                if (inc_idx(write_index) == read_index) begin
                  r_done <= 1'b1;
                end else if (read_index == write_index) begin
                  // empty ring: offset 0 if it fits the store at all
                  r_done <= 1'b1;
                  if ({2'b0, length} <= DataLim) begin
                    r_ok          <= 1'b1;
                    r_len         <= length;
                    write_pending <= 1'b1;
                  end
                end
              end
              OP_COMMIT:  if (!write_pending) r_done <= 1'b1;
              OP_GET: begin
                if (!read_held) begin
                  if (flush_request) begin
                    read_index    <= write_index;
                    flush_request <= 1'b0;
                    r_done        <= 1'b1;
                  end else if (read_index == write_index) begin
                    r_done <= 1'b1;
                  end else begin
                    read_held  <= 1'b1;
                    held_index <= read_index;
                    held_count <= HcW'(1);
                  end
                end
              end
              OP_GET_RUN: begin
                if (flush_request) begin
                  read_index    <= write_index;
                  flush_request <= 1'b0;
                  read_held     <= 1'b0;
                  held_count    <= '0;
                  r_done        <= 1'b1;
                end else if (read_index == write_index) begin
                  r_done <= 1'b1;
                end
                walk_idx <= read_index;
              end
              OP_RELEASE: begin
                r_done <= 1'b1;
                if (read_held) begin
                  read_index <= rel_index;
                  r_ok       <= 1'b1;
                  r_cnt      <= CntW'(held_count);
                  read_held  <= 1'b0;
                  held_count <= '0;
                end
              end
              OP_INVALIDATE: begin
                flush_request <= 1'b1;
                r_done        <= 1'b1;
                r_ok          <= 1'b1;
              end
              default: r_done <= 1'b1;
            endcase
          end
        end
        ST_RES_RD: begin
          new_ofs <= rd_ofs;
          new_end <= SumW'(rd_ofs) + SumW'(rd_res);
        end
        ST_RES_EV: begin
          r_done <= 1'b1;
          if (fit_end || fit_zero) begin
            r_ok          <= 1'b1;
            r_ofs         <= fit_end ? new_end[OfsW-1:0] : '0;
            r_len         <= req_len;
            write_pending <= 1'b1;
          end
        end
        ST_CMT_RD: begin
          write_index   <= inc_idx(write_index);
          write_pending <= 1'b0;
          r_done        <= 1'b1;
          r_ok          <= 1'b1;
          r_ofs         <= rd_ofs;
          r_len         <= clip_len;
          r_flg         <= req_flags;
          r_stp         <= req_stamp;
        end
        ST_GET_RD: begin
          r_done <= 1'b1;
          r_ok   <= 1'b1;
          r_ofs  <= rd_ofs;
          r_len  <= rd_len;
          r_flg  <= rd_flg;
          r_stp  <= rd_stp;
          r_cnt  <= CntW'(held_count);
        end
        ST_RUN_RD: begin
          // head of the run is always taken
          run_total <= SumW'(rd_len);
          run_end   <= SumW'(rd_ofs) + SumW'(rd_len);
          run_cnt   <= HcW'(1);
          run_ofs   <= rd_ofs;
          run_flags <= rd_flg;
          run_stamp <= rd_stp;
          walk_idx  <= inc_idx(walk_idx);
        end
        ST_RUN_EV: begin
          if (run_join) begin
            run_total <= join_total;
            run_end   <= SumW'(rd_ofs) + SumW'(rd_len);
            run_cnt   <= run_cnt + 1'b1;
            walk_idx  <= inc_idx(walk_idx);
          end else begin
            read_held  <= 1'b1;
            held_index <= read_index;
            held_count <= run_cnt;
            r_done     <= 1'b1;
            r_ok       <= 1'b1;
            r_ofs      <= run_ofs;
            r_len      <= run_total[LenW-1:0];
            r_flg      <= run_flags;
            r_stp      <= run_stamp;
            r_cnt      <= CntW'(run_cnt);
          end
        end
        default: r_done <= 1'b0;
      endcase
    end
  end

endmodule

FILE: tb/packet_descriptor_ring_manager_tb.sv
// ----------------------------------------------------------------------------
// packet_descriptor_ring_manager_tb
// drives reserve/commit/get/run/release/invalidate transactions with random
// gaps and checks every done strobe against a behavioral ring model
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module packet_descriptor_ring_manager_tb;
  import pdrm_pkg::*;

  localparam int unsigned RING_BYTES = DataBytesDefault;
  localparam int unsigned RING_SLOTS = DescriptorsDefault;
  localparam int IDLE_LIMIT = 5000;

  typedef struct packed {
    logic              ok;
    logic [OfsW-1:0]   offset;
    logic [LenW-1:0]   out_length;
    logic [FlagW-1:0]  out_flags;
    logic [StampW-1:0] out_stamp;
    logic [CntW-1:0]   count;
  } answer_t;

  // small scoreboard: holds the ring model and the queue of pending answers
  class ring_scoreboard;
    logic [OfsW-1:0]   slot_ofs[RING_SLOTS];
    logic [LenW-1:0]   slot_resv[RING_SLOTS];
    logic [LenW-1:0]   slot_len[RING_SLOTS];
    logic [FlagW-1:0]  slot_flags[RING_SLOTS];
    logic [StampW-1:0] slot_stamp[RING_SLOTS];
    int unsigned wr_idx, rd_idx, hold_idx, hold_cnt;
    bit reserved, holding, flush_pend;
    answer_t pending_answers[$];
    int errors;

    function new();
      wr_idx = 0; rd_idx = 0; hold_idx = 0; hold_cnt = 0;
      reserved = 0; holding = 0; flush_pend = 0; errors = 0;
    endfunction

    function answer_t slot_answer(int unsigned i, longint unsigned len, int unsigned cnt);
      answer_t a;
      a = '0;
      a.ok = 1; a.offset = slot_ofs[i]; a.out_length = len[LenW-1:0];
      a.out_flags = slot_flags[i]; a.out_stamp = slot_stamp[i]; a.count = cnt[CntW-1:0];
      return a;
    endfunction

    // note an accepted transaction and queue the answer it must produce
    function void note_request(op_t o, logic [LenW-1:0] len, logic [FlagW-1:0] fl,
                               logic [StampW-1:0] st, logic [LenW-1:0] mx);
      answer_t a;
      longint unsigned where_at, fin, total, prev_end, l;
      int unsigned newest, i, cnt;
      bit fits;
      a = '0;
      case (o)
        OP_RESERVE: begin
          fits = 0;
          if ((wr_idx + 1) % RING_SLOTS != rd_idx) begin
            if (rd_idx == wr_idx) begin
              fits = (len <= RING_BYTES); where_at = 0;
            end else begin
              newest = (wr_idx + RING_SLOTS - 1) % RING_SLOTS;
              fin = longint'(slot_ofs[newest]) + slot_resv[newest];
              if (slot_ofs[rd_idx] <= slot_ofs[newest]) begin
                if (fin + len < RING_BYTES) begin
                  fits = 1; where_at = fin;
                end else if (len < slot_ofs[rd_idx]) begin
                  fits = 1; where_at = 0;
                end
              end else if (fin + len <= slot_ofs[rd_idx]) begin
                fits = 1; where_at = fin;
              end
            end
          end
          if (fits) begin
            slot_ofs[wr_idx] = where_at[OfsW-1:0];
            slot_resv[wr_idx] = len;
            reserved = 1;
            a.ok = 1; a.offset = where_at[OfsW-1:0]; a.out_length = len;
          end
        end
        OP_COMMIT: begin
          if (reserved) begin
            slot_len[wr_idx] = (len > slot_resv[wr_idx]) ? slot_resv[wr_idx] : len;
            slot_flags[wr_idx] = fl;
            slot_stamp[wr_idx] = st;
            a = slot_answer(wr_idx, slot_len[wr_idx], 0);
            wr_idx = (wr_idx + 1) % RING_SLOTS;
            reserved = 0;
          end
        end
        OP_GET: begin
          if (holding) begin
            a = slot_answer(hold_idx, slot_len[hold_idx], hold_cnt);
          end else if (flush_pend) begin
            rd_idx = wr_idx; flush_pend = 0;
          end else if (rd_idx != wr_idx) begin
            holding = 1; hold_idx = rd_idx; hold_cnt = 1;
            a = slot_answer(rd_idx, slot_len[rd_idx], 1);
          end
        end
        OP_GET_RUN: begin
          if (flush_pend) begin
            rd_idx = wr_idx; flush_pend = 0; holding = 0; hold_cnt = 0;
          end else if (rd_idx != wr_idx) begin
            i = rd_idx;
            total = slot_len[i];
            prev_end = longint'(slot_ofs[i]) + slot_len[i];
            cnt = 1;
            i = (i + 1) % RING_SLOTS;
            while (i != wr_idx && cnt < RING_SLOTS) begin
              l = slot_len[i];
              if (longint'(slot_ofs[i]) != prev_end || total + l > mx || slot_flags[i] != 0)
                break;
              total += l;
              prev_end = longint'(slot_ofs[i]) + l;
              cnt++;
              i = (i + 1) % RING_SLOTS;
            end
            holding = 1; hold_idx = rd_idx; hold_cnt = cnt;
            a = slot_answer(rd_idx, total, cnt);
          end
        end
        OP_RELEASE: begin
          if (holding) begin
            rd_idx = (rd_idx + hold_cnt) % RING_SLOTS;
            a.ok = 1; a.count = hold_cnt[CntW-1:0];
            holding = 0; hold_cnt = 0;
          end
        end
        OP_INVALIDATE: begin
          flush_pend = 1; a.ok = 1;
        end
        default: ;
      endcase
      pending_answers.push_back(a);
    endfunction

    function void check_answer(answer_t got);
      answer_t e;
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result, actual %p", $time, got);
        errors++;
        return;
      end
      e = pending_answers.pop_front();
      if (got.ok !== e.ok)
        $display("%0t: ok expected %0d actual %0d", $time, e.ok, got.ok);
      if (got.offset !== e.offset)
        $display("%0t: offset expected %0h actual %0h", $time, e.offset, got.offset);
      if (got.out_length !== e.out_length)
        $display("%0t: out_length expected %0h actual %0h", $time, e.out_length,
                 got.out_length);
      if (got.out_flags !== e.out_flags)
        $display("%0t: out_flags expected %0h actual %0h", $time, e.out_flags,
                 got.out_flags);
      if (got.out_stamp !== e.out_stamp)
        $display("%0t: out_stamp expected %0h actual %0h", $time, e.out_stamp,
                 got.out_stamp);
      if (got.count !== e.count)
        $display("%0t: count expected %0d actual %0d", $time, e.count, got.count);
      if (got !== e) errors++;
    endfunction
  endclass

  logic              clk = 0;
  logic              rst = 1;
  logic              start = 0;
  logic              busy;
  logic [2:0]        op = '0;
  logic [LenW-1:0]   length = '0;
  logic [FlagW-1:0]  packet_flags = '0;
  logic [StampW-1:0] stamp = '0;
  logic [LenW-1:0]   max_total = '0;
  logic              done, ok;
  logic [OfsW-1:0]   offset;
  logic [LenW-1:0]   out_length;
  logic [FlagW-1:0]  out_flags;
  logic [StampW-1:0] out_stamp;
  logic [CntW-1:0]   count;

  ring_scoreboard sb = new();
  int idle_cycles = 0;

  packet_descriptor_ring_manager u_dut (
    .clk, .rst, .start, .busy, .op, .length, .packet_flags, .stamp, .max_total,
    .done, .ok, .offset, .out_length, .out_flags, .out_stamp, .count
  );

  always #5 clk = ~clk;

  // results are strobes: sample every edge and check in the scoreboard
  always @(posedge clk) begin
    if (!rst && done) sb.check_answer({ok, offset, out_length, out_flags, out_stamp, count});
  end

  // watchdog on cycles with no accepted transaction in either direction
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired");
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // issue one transaction after a random gap; start stays high until taken
  // and is only dropped when a gap or a drain follows
  task automatic send_txn(logic [2:0] o, logic [LenW-1:0] len, logic [FlagW-1:0] fl,
                          logic [StampW-1:0] st, logic [LenW-1:0] mx, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    start <= 1; op <= o; length <= len; packet_flags <= fl; stamp <= st;
    max_total <= mx;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(op_t'(o), len, fl, st, mx);
  endtask

  task automatic wait_drained();
    start <= 0;
    @(posedge clk);
    while (sb.pending_answers.size() != 0) @(posedge clk);
  endtask

  function automatic logic [StampW-1:0] rand_stamp();
    return StampW'({$urandom(), $urandom()});
  endfunction

  // random length biased toward small packets, with occasional extremes
  function automatic logic [LenW-1:0] rand_len();
    case ($urandom_range(0, 9))
      0: return LenW'($urandom_range(0, 1048576));
      1: return LenW'($urandom());
      2: return '0;
      default: return LenW'($urandom_range(1, 4096));
    endcase
  endfunction

  initial begin
    int n;
    int sel;
    bit gaps;
    logic [LenW-1:0] rl;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: empty ring corners, stale commit, extremes, undefined ops
    send_txn(OP_GET, 0, 0, 0, 0, 0);
    send_txn(OP_GET_RUN, 0, 0, 0, 0, 0);
    send_txn(OP_RELEASE, 0, 0, 0, 0, 0);
    send_txn(OP_COMMIT, 5, 1, 1, 0, 0);
    send_txn(3'd6, 21'h1FFFFF, 8'hFF, '1, '1, 0);
    send_txn(3'd7, 0, 0, 0, 0, 0);
    send_txn(OP_RESERVE, 21'd1048577, 0, 0, 0, 0);
    send_txn(OP_RESERVE, 21'd1048576, 0, 0, 0, 0);
    send_txn(OP_RESERVE, 21'd100, 0, 0, 0, 0);
    send_txn(OP_COMMIT, 21'h1FFFFF, 8'hFF, '1, 0, 0);
    send_txn(OP_RESERVE, 21'd200, 0, 0, 0, 0);
    send_txn(OP_COMMIT, 21'd150, 8'h00, 63'h1234, 0, 0);
    send_txn(OP_RESERVE, 21'd50, 0, 0, 0, 0);
    send_txn(OP_COMMIT, 21'd50, 8'h00, 63'h5, 0, 0);
    send_txn(OP_GET, 0, 0, 0, 0, 0);
    send_txn(OP_GET, 0, 0, 0, 0, 0);
    send_txn(OP_GET_RUN, 0, 0, 0, 21'h1FFFFF, 0);
    send_txn(OP_RELEASE, 0, 0, 0, 0, 0);
    send_txn(OP_GET_RUN, 0, 0, 0, 0, 0);
    send_txn(OP_RELEASE, 0, 0, 0, 0, 0);
    send_txn(OP_INVALIDATE, 0, 0, 0, 0, 0);
    send_txn(OP_GET_RUN, 0, 0, 0, 0, 0);
    send_txn(OP_INVALIDATE, 0, 0, 0, 0, 0);
    send_txn(OP_GET, 0, 0, 0, 0, 0);
    wait_drained();

    // random: mostly reserve/commit pairs with reader traffic mixed in
    for (n = 0; n < 1900; n++) begin
      gaps = (n / 150) % 3 != 1;
      if (n == 950) wait_drained();
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
        rl = rand_len();
        send_txn(OP_RESERVE, rl, 0, 0, LenW'($urandom()), gaps);
        send_txn(OP_COMMIT, ($urandom_range(0, 3) == 0) ? rand_len() : rl,
                 ($urandom_range(0, 2) == 0) ? 8'($urandom()) : 8'h00,
                 rand_stamp(), LenW'($urandom()), gaps);
        n++;
      end else if (sel < 50) send_txn(OP_GET, rand_len(), FlagW'($urandom()), rand_stamp(),
                                      LenW'($urandom()), gaps);
      else if (sel < 65) send_txn(OP_GET_RUN, rand_len(), FlagW'($urandom()), rand_stamp(),
                                  ($urandom_range(0, 4) == 0) ? 21'h1FFFFF : rand_len(), gaps);
      else if (sel < 85) send_txn(OP_RELEASE, rand_len(), FlagW'($urandom()), rand_stamp(),
                                  LenW'($urandom()), gaps);
      else if (sel < 88) send_txn(OP_INVALIDATE, rand_len(), FlagW'($urandom()), rand_stamp(),
                                  LenW'($urandom()), gaps);
      else if (sel < 90) send_txn(3'($urandom_range(6, 7)), rand_len(), FlagW'($urandom()),
                                  rand_stamp(), LenW'($urandom()), gaps);
      else if (sel < 95) send_txn(OP_COMMIT, rand_len(), FlagW'($urandom()), rand_stamp(),
                                  LenW'($urandom()), gaps);
      else send_txn(OP_RESERVE, rand_len(), FlagW'($urandom()), rand_stamp(),
                    LenW'($urandom()), gaps);
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending_answers.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: filelist.f
src/pdrm_pkg.sv
src/packet_descriptor_ring_manager.sv
tb/packet_descriptor_ring_manager_tb.sv
